// File: hw/rtl/vn3_pkg.sv
// Shared constants and types for the 3-D vector normalizer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package vn3_pkg;

   localparam int COMPONENT_WIDTH_DEFAULT = 32;

   // Result is signed Q2.30; the unsigned root is at most 2^30.
   localparam int OUT_W    = 32;
   localparam int ROOT_W   = 31;
   localparam int QUOT_W   = 61;   // floor(c^2 * 2^60 / S) is at most 2^60
   localparam int FRONT_LAT = 4;
   localparam int DIV_LAT  = QUOT_W;
   localparam int SQRT_LAT = ROOT_W;

   localparam logic [OUT_W-1:0] ONE_Q30 = 32'h4000_0000;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } vn3_meta_type;

endpackage

// File: hw/rtl/vn3_front.sv
// Front end: component magnitudes, squares and the sum of squares.
// Depends on vn3_pkg.
`timescale 1ns / 1ps

module vn3_front #(
   parameter int CW = vn3_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [2:0][CW-1:0]            comp,
   output logic                          out_valid,
   output vn3_pkg::vn3_meta_type         out_meta,
   output logic [2:0][2*CW-1:0]          csq,
   output logic [2*CW-1:0]               sum
);
   import vn3_pkg::*;

   localparam int SW = 2 * CW;
   localparam int K  = (CW + 1) / 2;
   localparam int HW = CW - K;

   logic [3:0]           valid_ff;
   vn3_meta_type         meta1_ff, meta2_ff, meta3_ff, meta4_ff;
   logic [2:0][CW-1:0]   mag_ff;
   logic [2:0][2*HW-1:0] hh_ff;
   logic [2:0][CW-1:0]   hl_ff;
   logic [2:0][2*K-1:0]  ll_ff;
   logic [2:0][SW-1:0]   sq_ff, sq_in;
   logic [2:0][SW-1:0]   csq_ff;
   logic [SW-1:0]        sum_ff, sum_in;
   vn3_meta_type         meta_in;

   always_comb begin
      meta_in.zero = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
      for (int i = 0; i < 3; i++) begin
         meta_in.neg[i] = comp[i][CW-1];
      end
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = ({{(SW-2*HW){1'b0}}, hh_ff[i]} << (2 * K))
                  + ({{(SW-CW){1'b0}}, hl_ff[i]} << (K + 1))
                  + {{(SW-2*K){1'b0}}, ll_ff[i]};
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // The most negative input negates to itself, which read unsigned
         // is its true magnitude.
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= comp[i][CW-1] ? (~comp[i] + 1'b1) : comp[i];
            hh_ff[i]  <= mag_ff[i][CW-1:K] * mag_ff[i][CW-1:K];
            hl_ff[i]  <= {{K{1'b0}}, mag_ff[i][CW-1:K]} * {{HW{1'b0}}, mag_ff[i][K-1:0]};
            ll_ff[i]  <= mag_ff[i][K-1:0] * mag_ff[i][K-1:0];
         end
         sq_ff    <= sq_in;
         csq_ff   <= sq_ff;
         sum_ff   <= sum_in;
         meta1_ff <= meta_in;
         meta2_ff <= meta1_ff;
         meta3_ff <= meta2_ff;
         meta4_ff <= meta3_ff;
      end
   end

   assign out_valid = valid_ff[FRONT_LAT-1];
   assign out_meta  = meta4_ff;
   assign csq       = csq_ff;
   assign sum       = sum_ff;

endmodule

// File: hw/rtl/vn3_div.sv
// Restoring divider, one quotient bit per pipeline stage.
// Computes floor(num * 2^(QUOT_W-1) / den) for num <= den. Depends on vn3_pkg.
`timescale 1ns / 1ps

module vn3_div #(
   parameter int SW = 2 * vn3_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [SW-1:0]              num,
   input  logic [SW-1:0]              den,
   output logic [vn3_pkg::QUOT_W-1:0] quot
);
   import vn3_pkg::*;

   logic [SW-1:0]     rem_ff [DIV_LAT];
   logic [SW-1:0]     den_ff [DIV_LAT];
   logic [QUOT_W-1:0] q_ff   [DIV_LAT];

   for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
      logic [SW:0]       part;
      logic [SW:0]       diff;
      logic [SW-1:0]     den_cur;
      logic [QUOT_W-1:0] q_cur;
      logic              ge;

      if (s == 0) begin : g_first
         assign part    = {1'b0, num};
         assign den_cur = den;
         assign q_cur   = '0;
      end else begin : g_next
         assign part    = {rem_ff[s-1], 1'b0};
         assign den_cur = den_ff[s-1];
         assign q_cur   = q_ff[s-1];
      end

      assign diff = part - {1'b0, den_cur};
      assign ge   = !diff[SW];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? diff[SW-1:0] : part[SW-1:0];
            den_ff[s] <= den_cur;
            q_ff[s]   <= q_cur | ({{(QUOT_W-1){1'b0}}, ge} << (QUOT_W - 1 - s));
         end
      end
   end

   assign quot = q_ff[DIV_LAT-1];

endmodule

// File: hw/rtl/vn3_sqrt.sv
// Digit-by-digit integer square root, one root bit per pipeline stage.
// Depends on vn3_pkg.
`timescale 1ns / 1ps

module vn3_sqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [vn3_pkg::QUOT_W-1:0] rad,
   output logic [vn3_pkg::ROOT_W-1:0] root
);
   import vn3_pkg::*;

   localparam int XW = 2 * ROOT_W;
   localparam int RW = ROOT_W + 3;

   logic [RW-1:0]     rem_ff  [SQRT_LAT];
   logic [ROOT_W-1:0] root_ff [SQRT_LAT];
   logic [XW-1:0]     x_ff    [SQRT_LAT];

   for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
      logic [RW-1:0]     rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [XW-1:0]     x_cur;
      logic [RW+1:0]     part;
      logic [RW+1:0]     trial;
      logic [RW+1:0]     diff;
      logic              ge;

      if (s == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign x_cur    = {{(XW-QUOT_W){1'b0}}, rad};
      end else begin : g_next
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
         assign x_cur    = x_ff[s-1];
      end

      assign part  = {rem_cur, x_cur[XW-1:XW-2]};
      assign trial = {{(RW-ROOT_W){1'b0}}, root_cur, 2'b01};
      assign diff  = part - trial;
      assign ge    = (part >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? diff[RW-1:0] : part[RW-1:0];
            root_ff[s] <= {root_cur[ROOT_W-2:0], ge};
            x_ff[s]    <= {x_cur[XW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQRT_LAT-1];

endmodule

// File: hw/rtl/vector_normalize_3d.sv
// Top level of the 3-D vector normalizer: front end, three divider and root lanes,
// sign and fallback stage, output skid buffer. Depends on vn3_pkg and all vn3_ modules.
//
//   Channel   Direction  Handshake                    Payload
//   req_      in         req_tvalid / req_tready      tdata: comp_x, comp_y, comp_z
//   rsp_      out        rsp_tvalid / rsp_tready      tdata: unit_x, unit_y, unit_z;
//                                                     tuser: degenerate
//   csr_      in         csr_valid / csr_ready        data: degenerate_mode
//
// One request is taken per cycle while the pipeline is not held; its result passes
// through 4 front-end stages, 61 divider stages, 31 root stages, a sign stage and the
// output register, the first front-end stage loading at the accepting edge.
// Reset clears all valid bits and the mode register; the CSR port is always ready.
// A stalled output fills a one-entry skid buffer, then the whole pipeline holds.
`timescale 1ns / 1ps

module vector_normalize_3d #(
   parameter int COMPONENT_WIDTH = vn3_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // comp_x, comp_y, comp_z from the low bits up, zero padded to bytes
   input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // unit_x, unit_y, unit_z from the low bits up
   output logic [3*vn3_pkg::OUT_W-1:0]                 rsp_tdata,
   // degenerate
   output logic                                        rsp_tuser,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic                                        csr_data
);
   import vn3_pkg::*;

   localparam int CW = COMPONENT_WIDTH;
   localparam int SW = 2 * CW;
   localparam int ML = DIV_LAT + SQRT_LAT;

   logic                  en;
   logic                  mode_ff;
   logic [2:0][CW-1:0]    comp;
   logic                  f_valid;
   vn3_meta_type          f_meta;
   logic [2:0][SW-1:0]    csq;
   logic [SW-1:0]         sum;
   logic [2:0][QUOT_W-1:0] quot;
   logic [2:0][ROOT_W-1:0] root;

   logic                  line_v_ff [ML];
   vn3_meta_type          line_m_ff [ML];

   logic                  pv_ff;
   logic [3*OUT_W-1:0]    pdata_ff, pdata_in;
   logic                  pdeg_ff;
   logic                  rsp_valid_ff, skid_valid_ff;
   logic [3*OUT_W-1:0]    rsp_data_ff, skid_data_ff;
   logic                  rsp_deg_ff, skid_deg_ff;
   logic                  rsp_take;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign comp[i] = req_tdata[i*CW +: CW];

      vn3_div #(.SW(SW)) u_div (
         .clock (clock),
         .en    (en),
         .num   (csq[i]),
         .den   (sum),
         .quot  (quot[i])
      );

      vn3_sqrt u_sqrt (
         .clock (clock),
         .en    (en),
         .rad   (quot[i]),
         .root  (root[i])
      );
   end

   vn3_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .comp      (comp),
      .out_valid (f_valid),
      .out_meta  (f_meta),
      .csq       (csq),
      .sum       (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   // Valid and sign/zero flags ride alongside the divider and root stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ML; s++) begin
            line_v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         line_v_ff[0] <= f_valid;
         for (int s = 1; s < ML; s++) begin
            line_v_ff[s] <= line_v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line_m_ff[0] <= f_meta;
         for (int s = 1; s < ML; s++) begin
            line_m_ff[s] <= line_m_ff[s-1];
         end
      end
   end

   always_comb begin
      logic [OUT_W-1:0] mag_ext;
      for (int i = 0; i < 3; i++) begin
         mag_ext = {{(OUT_W-ROOT_W){1'b0}}, root[i]};
         pdata_in[i*OUT_W +: OUT_W] = line_m_ff[ML-1].neg[i] ? (~mag_ext + 1'b1) : mag_ext;
      end
      if (line_m_ff[ML-1].zero) begin
         pdata_in = '0;
         if (mode_ff) begin
            pdata_in[OUT_W-1:0] = ONE_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= line_v_ff[ML-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pdata_ff <= pdata_in;
         pdeg_ff  <= line_m_ff[ML-1].zero;
      end
   end

   assign rsp_take = rsp_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take || !rsp_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (pv_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take || !rsp_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
            rsp_deg_ff  <= skid_deg_ff;
         end
      end else if (pv_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_ff <= pdata_ff;
            rsp_deg_ff  <= pdeg_ff;
         end else begin
            skid_data_ff <= pdata_ff;
            skid_deg_ff  <= pdeg_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_deg_ff;

endmodule

// File: test/vector_normalize_3d_tb.sv
// Self-checking testbench for vector_normalize_3d: directed and random vectors,
// random idling on both streams and a long output hold. Depends on vn3_pkg and the RTL.
`timescale 1ns / 1ps

class unit_vector_board;
   typedef struct {
      logic [31:0] ux, uy, uz;
      logic        degen;
   } unit_result_type;

   unit_result_type expected_units[$];
   bit              fallback_x;
   int              mismatches;

   // Largest q <= 2^30 with q^2 * sum <= mag^2 * 2^60, then signed.
   function automatic logic [31:0] scaled_quotient(logic [31:0] comp, logic [191:0] sumsq);
      logic [191:0] target;
      logic [191:0] lhs;
      logic [191:0] cand;
      logic [31:0]  mag;
      logic [31:0]  q;
      mag = comp[31] ? -comp : comp;
      target = (192'(mag) * 192'(mag)) << 60;
      q = 0;
      for (int b = 30; b >= 0; b--) begin
         cand = 192'(q | (32'd1 << b));
         lhs = cand * cand * sumsq;
         if (lhs <= target) q = q | (32'd1 << b);
      end
      return comp[31] ? -q : q;
   endfunction

   function void note(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      unit_result_type r;
      logic [191:0]    s;
      logic [31:0]     m[3];
      m[0] = cx[31] ? -cx : cx;
      m[1] = cy[31] ? -cy : cy;
      m[2] = cz[31] ? -cz : cz;
      if (cx == 0 && cy == 0 && cz == 0) begin
         r.ux = fallback_x ? vn3_pkg::ONE_Q30 : 32'd0;
         r.uy = 0;
         r.uz = 0;
         r.degen = 1'b1;
      end else begin
         s = 0;
         for (int i = 0; i < 3; i++) s += 192'(m[i]) * 192'(m[i]);
         r.ux = scaled_quotient(cx, s);
         r.uy = scaled_quotient(cy, s);
         r.uz = scaled_quotient(cz, s);
         r.degen = 1'b0;
      end
      expected_units.push_back(r);
   endfunction

   function void check(logic [95:0] tdata, logic tuser);
      unit_result_type e;
      if (expected_units.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h user %b", tdata, tuser);
         return;
      end
      e = expected_units.pop_front();
      if (tdata !== {e.uz, e.uy, e.ux} || tuser !== e.degen) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected x %h y %h z %h degen %b, got x %h y %h z %h degen %b",
                     e.ux, e.uy, e.uz, e.degen,
                     tdata[31:0], tdata[63:32], tdata[95:64], tuser);
      end
   endfunction
endclass

module vector_normalize_3d_tb;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_data = 0;

   unit_vector_board board = new();
   int  vectors_sent = 0;
   int  idle_cycles = 0;

   vector_normalize_3d dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   task automatic send_vector(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      int  gap;
      bit  ok;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {cz, cy, cx};
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      board.note(cx, cy, cz);
      vectors_sent++;
   endtask

   task automatic write_mode(logic mode);
      bit ok;
      req_tvalid <= 0;
      csr_valid <= 1;
      csr_data <= mode;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 0;
      board.fallback_x = mode;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      wait (board.expected_units.size() == 0);
      @(posedge clock);
      repeat (110) @(posedge clock);
   endtask

   function automatic logic [31:0] random_comp();
      case ($urandom_range(0, 3))
         0: return 32'($signed($urandom_range(0, 2000)) - 1000);
         1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic random_vectors(int count);
      logic [31:0] c[3];
      int          axis;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 3; i++) c[i] = random_comp();
         case ($urandom_range(0, 15))
            0: c = '{0, 0, 0};
            1, 2: begin
               // Only one axis carries a value.
               axis = $urandom_range(0, 2);
               for (int i = 0; i < 3; i++) if (i != axis) c[i] = 0;
            end
            3: c[$urandom_range(0, 2)] = 0;
            default: ;
         endcase
         send_vector(c[0], c[1], c[2]);
      end
   endtask

   // Output side: random stalls, plus one long hold while the input keeps going.
   initial begin
      int  gap;
      bit  ok;
      bit  held;
      logic [95:0] data;
      logic        user;
      held = 0;
      wait (!reset);
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
         if (!held && vectors_sent > 150) begin
            held = 1;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do begin
            @(negedge clock);
            ok = rsp_tvalid;
            data = rsp_tdata;
            user = rsp_tuser;
            @(posedge clock);
         end while (!ok);
         board.check(data, user);
      end
   end

   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("vector_normalize_3d test failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Zero-vector fallback in both modes, then the field extremes.
      write_mode(0);
      send_vector(0, 0, 0);
      drain();
      write_mode(1);
      send_vector(0, 0, 0);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(0, 32'h7fff_ffff, 0);
      send_vector(0, 0, 32'hffff_ffff);
      send_vector(32'h0000_0001, 0, 0);
      send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
      send_vector(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_vector(32'h0003_0000, 32'hfffc_0000, 0);
      send_vector(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
      send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
      random_vectors(400);
      drain();
      write_mode(0);
      random_vectors(400);
      drain();
      write_mode(1);
      random_vectors(280);
      drain();

      if (board.mismatches == 0 && board.expected_units.size() == 0)
         $display("vector_normalize_3d test passed");
      else
         $display("vector_normalize_3d test failed");
      $finish;
   end
endmodule
